// ----- sv/kcl_pkg.sv -----
// Shared types and constants for the keypad and tag code lock.
`timescale 1ns / 1ps

package kcl_pkg;

  // Log ring size and derived widths
  localparam int HISTORY_DEPTH = 20;
  localparam int LOG_AW        = $clog2(HISTORY_DEPTH);
  localparam int LOG_DW        = 11;

  // Clock limits
  localparam int MIN_PER_HOUR = 60;
  localparam int HOUR_PER_DAY = 24;

  // Configuration register reset values
  localparam logic [31:0] TAG_A_RST = 32'h3E1B_ED00;
  localparam logic [31:0] TAG_B_RST = 32'h0813_2491;
  localparam logic [7:0]  TPM_RST   = 8'd10;

  // Key codes
  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_STAR       = 4'd10;

  // Digits per code
  localparam logic [2:0] CODE_DIGITS = 3'd4;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_KEY  = 2'd1,
    ACT_TAG  = 2'd2,
    ACT_HIST = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_DIGIT    = 4'd1,
    EV_CODE_OK  = 4'd2,
    EV_CODE_BAD = 4'd3,
    EV_CHANGE   = 4'd4,
    EV_STORED   = 4'd5,
    EV_TAG_OK   = 4'd6,
    EV_TAG_BAD  = 4'd7,
    EV_CLOSED   = 4'd8,
    EV_HISTORY  = 4'd9
  } event_t;

  typedef enum logic [1:0] {
    CFG_TAG_A = 2'd0,
    CFG_TAG_B = 2'd1,
    CFG_TPM   = 2'd2
  } cfg_idx_t;

endpackage

// ----- sv/kcl_in_if.sv -----
// Input channel: one action word per handshake.
`timescale 1ns / 1ps

interface kcl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  key_code;
  logic [31:0] tag_uid;
  logic [4:0]  history_index;

  modport source (output valid, action, key_code, tag_uid, history_index, input ready);
  modport sink   (input valid, action, key_code, tag_uid, history_index, output ready);
endinterface

// ----- sv/kcl_out_if.sv -----
// Result channel: one result word per handshake.
`timescale 1ns / 1ps

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic       door_open;
  logic [4:0] clock_hour;
  logic [5:0] clock_minute;
  logic       log_valid;
  logic [4:0] log_hour;
  logic [5:0] log_minute;

  modport source (output valid, event_res, door_open, clock_hour, clock_minute,
                  log_valid, log_hour, log_minute, input ready);
  modport sink   (input valid, event_res, door_open, clock_hour, clock_minute,
                  log_valid, log_hour, log_minute, output ready);
endinterface

// ----- sv/kcl_cfg_if.sv -----
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface kcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- sv/keypad_tag_code_lock_top.sv -----
// Code lock controller: keypad code, tag check, minute clock and entry log.
//
// Usage:
//   in_ch  : one word per action (tick, key press, tag read, history read).
//   out_ch : exactly one result word per accepted input word, in order.
//   cfg_ch : writes tag_a (0), tag_b (1), ticks_per_minute (2); always ready.
//            Write only while no word is in flight.
// Pipeline: an accepted input word passes the middle stage (state update
//   and log memory read) and then the output register before its result
//   is valid.
// Throughput: one word per cycle unless out_ch stalls. All lock and clock
//   state updates in the accept cycle; the log ring is a single-port-write,
//   one-read memory with registered read data, and a read never hits the slot
//   written by the same word, so words follow back to back.
// Stall: a stalled output holds its word; one more word can be taken into
//   the middle stage, after which in_ch.ready drops until out_ch drains.
// Reset (rst_n low, synchronous): code 0000, door closed, clock 00:00,
//   log empty, tags and tick rate back to defaults. The log memory itself
//   is not cleared; per-slot written flags mask stale entries.
`timescale 1ns / 1ps

module keypad_tag_code_lock_top
  import kcl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  kcl_in_if.sink    in_ch,
  kcl_out_if.source out_ch,
  kcl_cfg_if.sink   cfg_ch
);

  // Configuration registers
  logic [31:0] tag_a_r, tag_b_r;
  logic [7:0]  tpm_r;

  // Lock and clock state
  logic [15:0] stored_code_r, stored_code_nxt;
  logic [15:0] digits_r, digits_nxt;
  logic [2:0]  entry_cnt_r, entry_cnt_nxt;
  logic [1:0]  star_cnt_r, star_cnt_nxt;
  logic        changing_r, changing_nxt;
  logic        door_r, door_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [HISTORY_DEPTH-1:0] written_r, written_nxt;
  logic [LOG_AW-1:0]        log_next_r, log_next_nxt;

  // Log memory
  logic [LOG_DW-1:0] log_mem [HISTORY_DEPTH];
  logic [LOG_DW-1:0] rd_q_r;
  logic              wr_en;
  logic [LOG_AW-1:0] wr_addr, rd_addr;

  // Middle stage
  logic       p_vld_r;
  event_t     p_ev_r;
  logic       p_door_r;
  logic [4:0] p_hour_r;
  logic [5:0] p_min_r;
  logic       p_lv_r;

  // Output stage
  logic       o_vld_r;
  logic [3:0] o_ev_r;
  logic       o_door_r;
  logic [4:0] o_hour_r;
  logic [5:0] o_min_r;
  logic       o_lv_r;
  logic [4:0] o_lhour_r;
  logic [5:0] o_lmin_r;

  // Per-word decode
  event_t      ev;
  logic        lv;
  logic        acc, adv;
  logic        is_digit, idx_ok;
  logic [15:0] digits_sh;
  logic [2:0]  cnt_inc;
  logic [7:0]  tick_inc;
  logic [LOG_AW-1:0] slot_inc;

  // Handshake
  assign adv         = p_vld_r && (!o_vld_r || out_ch.ready);
  assign in_ch.ready = !p_vld_r || adv;
  assign acc         = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= TAG_A_RST;
      tag_b_r <= TAG_B_RST;
      tpm_r   <= TPM_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TAG_A: tag_a_r <= cfg_ch.wdata;
        CFG_TAG_B: tag_b_r <= cfg_ch.wdata;
        CFG_TPM:   tpm_r   <= cfg_ch.wdata[7:0];
        default:   ;
      endcase
    end
  end

  // Next-state logic for one word
  assign is_digit  = in_ch.key_code <= KEY_LAST_DIGIT;
  assign digits_sh = {digits_r[11:0], in_ch.key_code};
  assign cnt_inc   = entry_cnt_r + 3'd1;
  assign tick_inc  = tick_r + 8'd1;
  assign slot_inc  = (int'(log_next_r) + 1 >= HISTORY_DEPTH) ? '0
                                                             : log_next_r + LOG_AW'(1);
  assign idx_ok    = int'(in_ch.history_index) < HISTORY_DEPTH;
  assign rd_addr   = idx_ok ? LOG_AW'(in_ch.history_index) : '0;
  assign wr_addr   = log_next_r;

  always_comb begin
    stored_code_nxt = stored_code_r;
    digits_nxt      = digits_r;
    entry_cnt_nxt   = entry_cnt_r;
    star_cnt_nxt    = star_cnt_r;
    changing_nxt    = changing_r;
    door_nxt        = door_r;
    tick_nxt        = tick_r;
    minute_nxt      = minute_r;
    hour_nxt        = hour_r;
    written_nxt     = written_r;
    log_next_nxt    = log_next_r;
    wr_en           = 1'b0;
    ev              = EV_NONE;
    lv              = 1'b0;

    unique case (in_ch.action)
      ACT_TICK: begin
        tick_nxt = tick_inc;
        if (tick_inc >= tpm_r) begin
          tick_nxt = '0;
          if (int'(minute_r) + 1 >= MIN_PER_HOUR) begin
            minute_nxt = '0;
            hour_nxt   = (int'(hour_r) + 1 >= HOUR_PER_DAY) ? '0 : hour_r + 5'd1;
          end else begin
            minute_nxt = minute_r + 6'd1;
          end
        end
      end
      ACT_KEY: begin
        if (changing_r) begin
          // new code entry
          if (is_digit) begin
            digits_nxt = digits_sh;
            if (cnt_inc >= CODE_DIGITS) begin
              stored_code_nxt = digits_sh;
              entry_cnt_nxt   = '0;
              changing_nxt    = 1'b0;
              star_cnt_nxt    = '0;
              ev              = EV_STORED;
            end else begin
              entry_cnt_nxt = cnt_inc;
              ev            = EV_DIGIT;
            end
          end
        end else if (in_ch.key_code == KEY_STAR) begin
          if (door_r) begin
            door_nxt     = 1'b0;
            star_cnt_nxt = '0;
            ev           = EV_CLOSED;
          end else if (star_cnt_r != 2'd0) begin
            star_cnt_nxt  = '0;
            entry_cnt_nxt = '0;
            changing_nxt  = 1'b1;
            ev            = EV_CHANGE;
          end else begin
            star_cnt_nxt = star_cnt_r + 2'd1;
          end
        end else begin
          star_cnt_nxt = '0;
          if (is_digit && !door_r) begin
            digits_nxt = digits_sh;
            if (cnt_inc >= CODE_DIGITS) begin
              entry_cnt_nxt = '0;
              if (digits_sh == stored_code_r) begin
                wr_en = 1'b1;
                ev    = EV_CODE_OK;
              end else begin
                ev = EV_CODE_BAD;
              end
            end else begin
              entry_cnt_nxt = cnt_inc;
              ev            = EV_DIGIT;
            end
          end
        end
      end
      ACT_TAG: begin
        if (!door_r && !changing_r) begin
          if (in_ch.tag_uid == tag_a_r || in_ch.tag_uid == tag_b_r) begin
            wr_en = 1'b1;
            ev    = EV_TAG_OK;
          end else begin
            ev = EV_TAG_BAD;
          end
        end
      end
      ACT_HIST: begin
        ev = EV_HISTORY;
        lv = idx_ok && written_r[rd_addr];
      end
      default: ;
    endcase

    // opening logs the time into the next ring slot
    if (wr_en) begin
      door_nxt             = 1'b1;
      written_nxt[wr_addr] = 1'b1;
      log_next_nxt         = slot_inc;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_code_r <= '0;
      digits_r      <= '0;
      entry_cnt_r   <= '0;
      star_cnt_r    <= '0;
      changing_r    <= 1'b0;
      door_r        <= 1'b0;
      tick_r        <= '0;
      minute_r      <= '0;
      hour_r        <= '0;
      written_r     <= '0;
      log_next_r    <= '0;
    end else if (acc) begin
      stored_code_r <= stored_code_nxt;
      digits_r      <= digits_nxt;
      entry_cnt_r   <= entry_cnt_nxt;
      star_cnt_r    <= star_cnt_nxt;
      changing_r    <= changing_nxt;
      door_r        <= door_nxt;
      tick_r        <= tick_nxt;
      minute_r      <= minute_nxt;
      hour_r        <= hour_nxt;
      written_r     <= written_nxt;
      log_next_r    <= log_next_nxt;
    end
  end

  // Log memory: write on opening, registered read on every accepted word
  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      log_mem[wr_addr] <= {hour_r, minute_r};
    end
    if (acc) begin
      rd_q_r <= log_mem[rd_addr];
    end
  end

  // Middle stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (acc) begin
      p_vld_r <= 1'b1;
    end else if (adv) begin
      p_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_ev_r   <= ev;
      p_door_r <= door_nxt;
      p_hour_r <= hour_nxt;
      p_min_r  <= minute_nxt;
      p_lv_r   <= lv;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_ev_r    <= p_ev_r;
      o_door_r  <= p_door_r;
      o_hour_r  <= p_hour_r;
      o_min_r   <= p_min_r;
      o_lv_r    <= p_lv_r;
      o_lhour_r <= p_lv_r ? rd_q_r[10:6] : '0;
      o_lmin_r  <= p_lv_r ? rd_q_r[5:0]  : '0;
    end
  end

  assign out_ch.valid        = o_vld_r;
  assign out_ch.event_res    = o_ev_r;
  assign out_ch.door_open    = o_door_r;
  assign out_ch.clock_hour   = o_hour_r;
  assign out_ch.clock_minute = o_min_r;
  assign out_ch.log_valid    = o_lv_r;
  assign out_ch.log_hour     = o_lhour_r;
  assign out_ch.log_minute   = o_lmin_r;

`ifndef ASSERT_OFF
  // clock stays in range
  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(hour_r) < HOUR_PER_DAY && int'(minute_r) < MIN_PER_HOUR)
    else $error("clock out of range");

  // ring pointer stays inside the log
  a_ring_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    int'(log_next_r) < HISTORY_DEPTH)
    else $error("log pointer out of range");

  // code change is only entered with the door closed, and nothing opens it
  a_change_closed: assert property (@(posedge clk) disable iff (!rst_n)
    changing_r |-> !door_r)
    else $error("door open during code change");

  // a middle-stage word held back by a full output keeps its event
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r && !adv |=> p_vld_r && $stable(p_ev_r) && $stable(rd_q_r))
    else $error("middle stage lost a stalled word");
`endif

endmodule
